// File: rtl/drpr_pkg.sv
package drpr_pkg;

    localparam int DEN_W  = 50;
    localparam int DVS_W  = 49;
    localparam int QUO_W  = 61;
    localparam int NUM_W  = 33;
    localparam int SHR_W  = 66;
    localparam int PIX_W  = 12;
    localparam int DISP_W = 16;
    localparam int CFG_W  = 32;
    localparam int LIM_W  = 31;

    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_ROWS_DEF = 4096;

    localparam logic signed [31:0] FOCAL_RST = 32'sd274122;
    localparam logic signed [31:0] IBASE_RST = 32'sd833244;
    localparam logic signed [31:0] DOFF_RST  = 32'sd0;
    localparam logic signed [31:0] CX_RST    = -32'sd166483;
    localparam logic signed [31:0] CY_RST    = -32'sd127322;
    localparam logic [LIM_W-1:0]   LIMIT_RST = 31'd3145728;

    typedef enum logic [2:0] {
        REG_FOCAL = 3'd0,
        REG_IBASE = 3'd1,
        REG_DOFF  = 3'd2,
        REG_CX    = 3'd3,
        REG_CY    = 3'd4,
        REG_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic             valid;
        logic [DVS_W-1:0] dvs;
        logic [DVS_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
    } div_t;

endpackage

// File: rtl/drpr_div_cell.sv
module drpr_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           lead,
    input  drpr_pkg::div_t cell_in,
    output drpr_pkg::div_t cell_out
);

    drpr_pkg::div_t             cell_reg;
    drpr_pkg::div_t             cell_next;
    logic [drpr_pkg::DVS_W:0]   rem_sh;
    logic                       ge;

    always_comb begin
        rem_sh    = {cell_in.rem, lead};
        ge        = rem_sh >= {1'b0, cell_in.dvs};
        cell_next = cell_in;
        if (ge) begin
            cell_next.rem = drpr_pkg::DVS_W'(rem_sh - {1'b0, cell_in.dvs});
        end else begin
            cell_next.rem = rem_sh[drpr_pkg::DVS_W-1:0];
        end
        cell_next.quo = {cell_in.quo[drpr_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// File: rtl/drpr_coord.sv
module drpr_coord (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [drpr_pkg::NUM_W-1:0]  num_mag,
    input  logic [drpr_pkg::QUO_W-1:0]  pw_mag,
    output logic [drpr_pkg::SHR_W-1:0]  prod_shr
);

    localparam int LO_W  = 31;
    localparam int HI_W  = drpr_pkg::QUO_W - LO_W;
    localparam int SUM_W = drpr_pkg::NUM_W + drpr_pkg::QUO_W;

    logic [drpr_pkg::NUM_W+LO_W-1:0] plo_reg;
    logic [drpr_pkg::NUM_W+HI_W-1:0] phi_reg;
    logic [drpr_pkg::SHR_W-1:0]      shr_reg;
    logic [SUM_W-1:0]                sum;

    assign sum = SUM_W'(plo_reg) + (SUM_W'(phi_reg) << LO_W);

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= num_mag * pw_mag[LO_W-1:0];
            phi_reg <= num_mag * pw_mag[drpr_pkg::QUO_W-1:LO_W];
            shr_reg <= sum[SUM_W-1:28];
        end
    end

    assign prod_shr = shr_reg;

endmodule

// File: rtl/disparity_to_point_reprojection.sv
// Channel | Ports          | Fields (low bit up)
// input   | s_axis_t*      | tdata: disparity[15:0], column[27:16], row[39:28]
// result  | m_axis_t*      | tdata: point_x[31:0], point_y[63:32], point_z[95:64]
// config  | cfg_*          | cfg_addr selects register, cfg_wdata is the value
// One beat per clock unless the output stalls; the pipeline has two setup stages, one divider cell per
// quotient bit (61 cells), one numerator stage, two multiply stages, one output stage.
// Reset (aresetn low, synchronous) empties the pipeline and reloads the registers.
// A held output beat stalls the whole chain; s_axis_tready is high while the output is empty or m_axis_tready is high.
// Dropped pixels occupy a slot but produce no beat.
module disparity_to_point_reprojection #(
    parameter int MAX_COLS = drpr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = drpr_pkg::MAX_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // disparity, column, row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // point_x, point_y, point_z
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int NCELL = drpr_pkg::QUO_W;
    localparam int DEN_W = drpr_pkg::DEN_W;
    localparam int PIX_W = drpr_pkg::PIX_W;
    localparam int SHR_W = drpr_pkg::SHR_W;
    localparam int NUM_W = drpr_pkg::NUM_W;

    logic signed [31:0] focal_reg, ibase_reg, doff_reg, cx_reg, cy_reg;
    logic [drpr_pkg::LIM_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= drpr_pkg::FOCAL_RST;
            ibase_reg <= drpr_pkg::IBASE_RST;
            doff_reg  <= drpr_pkg::DOFF_RST;
            cx_reg    <= drpr_pkg::CX_RST;
            cy_reg    <= drpr_pkg::CY_RST;
            limit_reg <= drpr_pkg::LIMIT_RST;
        end else if (cfg_we) begin
            case (drpr_pkg::cfg_idx_t'(cfg_addr))
                drpr_pkg::REG_FOCAL: focal_reg <= cfg_wdata;
                drpr_pkg::REG_IBASE: ibase_reg <= cfg_wdata;
                drpr_pkg::REG_DOFF:  doff_reg  <= cfg_wdata;
                drpr_pkg::REG_CX:    cx_reg    <= cfg_wdata;
                drpr_pkg::REG_CY:    cy_reg    <= cfg_wdata;
                drpr_pkg::REG_LIMIT: limit_reg <= cfg_wdata[drpr_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic m_valid_reg;
    logic en;
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic [drpr_pkg::DISP_W-1:0] disp;
    logic [PIX_W-1:0]            col_in, row_in;
    logic                        ok_in;
    logic signed [DEN_W-1:0]     den_c;
    assign disp   = s_axis_tdata[15:0];
    assign col_in = s_axis_tdata[27:16];
    assign row_in = s_axis_tdata[39:28];
    assign ok_in  = s_axis_tvalid && (disp != '0) && (32'(col_in) < MAX_COLS)
                    && (32'(row_in) < MAX_ROWS);
    assign den_c  = ($signed({1'b0, disp}) * ibase_reg) + (DEN_W'(doff_reg) <<< 4);

    logic                    v1_reg;
    logic signed [DEN_W-1:0] den1_reg;
    logic [PIX_W-1:0]        col1_reg, row1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ok_in;
        end
        if (en) begin
            den1_reg <= den_c;
            col1_reg <= col_in;
            row1_reg <= row_in;
        end
    end

    logic [DEN_W-1:0] den_abs;
    assign den_abs = den1_reg[DEN_W-1] ? DEN_W'(-den1_reg) : DEN_W'(den1_reg);

    drpr_pkg::div_t chain [NCELL+1];
    drpr_pkg::div_t head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else if (en) begin
            head_reg.valid <= v1_reg && (den1_reg != '0);
            head_reg.dvs   <= den_abs[drpr_pkg::DVS_W-1:0];
            head_reg.rem   <= '0;
            head_reg.quo   <= '0;
            head_reg.neg   <= den1_reg[DEN_W-1];
            head_reg.col   <= col1_reg;
            head_reg.row   <= row1_reg;
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        drpr_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .lead     (i == 0),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    drpr_pkg::div_t tail;
    assign tail = chain[NCELL];

    logic signed [NUM_W:0] xn, yn;
    assign xn = $signed({2'b0, tail.col, 8'b0}) + cx_reg;
    assign yn = $signed({2'b0, tail.row, 8'b0}) + cy_reg;

    logic                  v4_reg, xneg4_reg, yneg4_reg, zneg4_reg;
    logic [NUM_W-1:0]      xm4_reg, ym4_reg, fm4_reg;
    logic [NCELL-1:0]      pw4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= tail.valid;
        end
        if (en) begin
            xneg4_reg <= xn[NUM_W] != tail.neg;
            yneg4_reg <= yn[NUM_W] != tail.neg;
            zneg4_reg <= focal_reg[31] != tail.neg;
            xm4_reg   <= xn[NUM_W] ? NUM_W'(-xn) : NUM_W'(xn);
            ym4_reg   <= yn[NUM_W] ? NUM_W'(-yn) : NUM_W'(yn);
            fm4_reg   <= focal_reg[31] ? NUM_W'(-NUM_W'(focal_reg)) : NUM_W'(focal_reg);
            pw4_reg   <= tail.quo;
        end
    end

    logic [SHR_W-1:0] xs, ys, zs;

    drpr_coord u_x (.aclk(aclk), .en(en), .num_mag(xm4_reg), .pw_mag(pw4_reg), .prod_shr(xs));
    drpr_coord u_y (.aclk(aclk), .en(en), .num_mag(ym4_reg), .pw_mag(pw4_reg), .prod_shr(ys));
    drpr_coord u_z (.aclk(aclk), .en(en), .num_mag(fm4_reg), .pw_mag(pw4_reg), .prod_shr(zs));

    logic [1:0] v_reg, xneg_reg, yneg_reg, zneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], v4_reg};
        end
        if (en) begin
            xneg_reg <= {xneg_reg[0], xneg4_reg};
            yneg_reg <= {yneg_reg[0], yneg4_reg};
            zneg_reg <= {zneg_reg[0], zneg4_reg};
        end
    end

    function automatic logic [31:0] sat(input logic [SHR_W-1:0] s, input logic neg);
        logic [32:0] m;
        if (neg) begin
            m   = (s > SHR_W'(33'h100000000 >> 1)) ? 33'h080000000 : s[32:0];
            sat = 32'(-m);
        end else begin
            sat = (s > SHR_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : s[31:0];
        end
    endfunction

    logic [63:0] zm;
    logic        zneg_eff, keep;
    logic [31:0] zout;
    assign zm       = zs[63:0];
    assign zneg_eff = zneg_reg[1] && (zm != '0);
    assign keep     = v_reg[1] && (zs[SHR_W-1:64] == '0) &&
                      (zneg_eff ? (zm <= 64'(limit_reg)) : (zm < 64'(limit_reg)));
    assign zout     = zneg_eff ? 32'(-zm[31:0]) : zm[31:0];

    logic [95:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= keep;
        end
        if (en) begin
            m_data_reg <= {zout, sat(ys, yneg_reg[1]), sat(xs, xneg_reg[1])};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
